// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// Each macro expects a signal named clk in the scope of its use; TKS_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define TKS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define TKS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/tks_pkg.sv -----
// Package of the top-k score tracker: field widths, limits and shared types.
// Used by every module of the tracker; depends on nothing.
`default_nettype none

package tks_pkg;

  localparam int TOP_ENTRIES = 5;

  localparam int NUM_W  = 14;
  localparam int RAW_W  = 32;
  localparam int Q_W    = 7;
  localparam int CNT_W  = 14;
  localparam int SUM_W  = 21;
  localparam int RANK_W = 3;

  localparam logic [Q_W-1:0]   SCORE_CAP = 7'd100;
  localparam logic [CNT_W-1:0] COUNT_MAX = 14'd16383;
  localparam logic [SUM_W-1:0] SUM_MAX   = 21'h1FFFFF;

  typedef struct packed {
    logic                    vld;
    logic [NUM_W-1:0]        num;
    logic signed [RAW_W-1:0] raw;
    logic [Q_W-1:0]          q;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic           upd;
    logic           ok;
    logic           clr;
    logic [Q_W-1:0] q;
  } stats_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] ok_cnt;
    logic [CNT_W-1:0] fail_cnt;
    logic [Q_W-1:0]   lo;
    logic [Q_W-1:0]   hi;
    logic [SUM_W-1:0] sum;
  } stats_t;

  localparam stats_t STATS_RST = '{
    ok_cnt:   '0,
    fail_cnt: '0,
    lo:       SCORE_CAP,
    hi:       '0,
    sum:      '0
  };

endpackage

`default_nettype wire

// ----- rtl/core/top_k_score_tracker_with_stats.sv -----
// Top level of the top-k score tracker: a chain of sorting cells plus statistics.
// Depends on tks_pkg, tks_cell and tks_stats.
// The statistics beat appears in the cycle after an item is accepted.
// Throughput: one item per cycle while no item carries the last-image flag.
// A last image is followed by one top-list beat per filled entry, one per cycle, shifted
// out of the cell chain; busy stays high until the cycle after the final beat of that run.
// Reset is synchronous and clears the list and statistics at once; no clearing pass.
`default_nettype none

module top_k_score_tracker_with_stats (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [tks_pkg::NUM_W-1:0]      in_image_number,
  input  logic signed [tks_pkg::RAW_W-1:0] in_raw_score,
  input  logic [tks_pkg::Q_W-1:0]        in_quality_score,
  input  logic                           in_scored_ok,
  input  logic                           in_last_image,
  output logic                           out_valid,
  output logic                           out_record_kind,
  output logic [tks_pkg::CNT_W-1:0]      out_succeeded_count,
  output logic [tks_pkg::CNT_W-1:0]      out_failed_count,
  output logic [tks_pkg::Q_W-1:0]        out_min_score,
  output logic [tks_pkg::Q_W-1:0]        out_max_score,
  output logic [tks_pkg::SUM_W-1:0]      out_score_total,
  output logic [tks_pkg::RANK_W-1:0]     out_rank,
  output logic [tks_pkg::NUM_W-1:0]      out_top_image_number,
  output logic signed [tks_pkg::RAW_W-1:0] out_top_raw_score,
  output logic [tks_pkg::Q_W-1:0]        out_top_quality_score,
  output logic                           out_last_of_run
);
  import tks_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic              accept;
  logic [Q_W-1:0]    q_sat;
  entry_t            new_ent;
  entry_t            ents  [TOP_ENTRIES];
  logic              downs [TOP_ENTRIES];
  cell_ctl_t         cell_ctl;
  stats_ctl_t        st_ctl;
  stats_t            st;
  logic              list_nonempty;

  logic              out_valid_r, out_valid_nxt;
  logic              out_end_r, out_end_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic              out_last_r, out_last_nxt;
  logic [RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic [NUM_W-1:0]  out_num_r, out_num_nxt;
  logic signed [RAW_W-1:0] out_raw_r, out_raw_nxt;
  logic [Q_W-1:0]    out_q_r, out_q_nxt;

  assign busy   = (state_r == ST_READ) || (out_valid_r && out_end_r);
  assign accept = start && !busy;
  assign q_sat  = (in_quality_score > SCORE_CAP) ? SCORE_CAP : in_quality_score;

  assign new_ent = '{vld: 1'b1, num: in_image_number, raw: in_raw_score, q: q_sat};

  assign cell_ctl.ins   = accept && in_scored_ok;
  assign cell_ctl.shift = (state_r == ST_READ);

  genvar gi;
  generate
    for (gi = 0; gi < TOP_ENTRIES; gi++) begin : g_cell
      entry_t left_e;
      entry_t right_e;
      logic   left_d;
      if (gi == 0) begin : g_head
        assign left_e = '0;
        assign left_d = 1'b0;
      end else begin : g_body
        assign left_e = ents[gi-1];
        assign left_d = downs[gi-1];
      end
      if (gi == TOP_ENTRIES - 1) begin : g_tail
        assign right_e = '0;
      end else begin : g_inner
        assign right_e = ents[gi+1];
      end
      tks_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cell_ctl),
        .new_ent   (new_ent),
        .left_ent  (left_e),
        .left_down (left_d),
        .right_ent (right_e),
        .ent       (ents[gi]),
        .down      (downs[gi])
      );
    end
  endgenerate

  assign st_ctl.upd = accept;
  assign st_ctl.ok  = in_scored_ok;
  assign st_ctl.clr = out_valid_r && out_end_r;
  assign st_ctl.q   = q_sat;

  tks_stats u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (st_ctl),
    .st    (st)
  );

  assign list_nonempty = ents[0].vld || in_scored_ok;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_end_nxt   = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_rank_nxt  = out_rank_r;
    out_num_nxt   = out_num_r;
    out_raw_nxt   = out_raw_r;
    out_q_nxt     = out_q_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_rank_nxt  = '0;
          out_num_nxt   = '0;
          out_raw_nxt   = '0;
          out_q_nxt     = '0;
          out_last_nxt  = !(in_last_image && list_nonempty);
          out_end_nxt   = in_last_image && !list_nonempty;
          if (in_last_image && list_nonempty) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = 1'b1;
        out_rank_nxt  = out_kind_r ? out_rank_r + 1'b1 : '0;
        out_num_nxt   = ents[0].num;
        out_raw_nxt   = ents[0].raw;
        out_q_nxt     = ents[0].q;
        out_last_nxt  = (TOP_ENTRIES == 1) ? 1'b1 : !ents[TOP_ENTRIES > 1 ? 1 : 0].vld;
        out_end_nxt   = out_last_nxt;
        if (out_last_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_end_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_end_r   <= out_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_rank_r <= out_rank_nxt;
    out_num_r  <= out_num_nxt;
    out_raw_r  <= out_raw_nxt;
    out_q_r    <= out_q_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_record_kind       = out_kind_r;
  assign out_succeeded_count   = st.ok_cnt;
  assign out_failed_count      = st.fail_cnt;
  assign out_min_score         = st.lo;
  assign out_max_score         = st.hi;
  assign out_score_total       = st.sum;
  assign out_rank              = out_rank_r;
  assign out_top_image_number  = out_num_r;
  assign out_top_raw_score     = out_raw_r;
  assign out_top_quality_score = out_q_r;
  assign out_last_of_run       = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/core/tks_cell.sv -----
// One cell of the sorted top list: holds one registered entry, inserts or shifts.
// Depends on tks_pkg.
`default_nettype none

module tks_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tks_pkg::cell_ctl_t ctl,
  input  tks_pkg::entry_t    new_ent,
  input  tks_pkg::entry_t    left_ent,
  input  logic               left_down,
  input  tks_pkg::entry_t    right_ent,
  output tks_pkg::entry_t    ent,
  output logic               down
);
  import tks_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  assign down = ctl.ins && (!ent_r.vld || (new_ent.raw > ent_r.raw));
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    priority if (ctl.shift) begin
      ent_nxt = right_ent;
    end else if (down) begin
      ent_nxt = left_down ? left_ent : new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tks_stats.sv -----
// Running statistics of the tracker: saturating counts, lowest and highest score, sum.
// Depends on tks_pkg.
`default_nettype none

module tks_stats (
  input  logic                clk,
  input  logic                rst_n,
  input  tks_pkg::stats_ctl_t ctl,
  output tks_pkg::stats_t     st
);
  import tks_pkg::*;

  stats_t           st_r;
  stats_t           st_nxt;
  logic [SUM_W:0]   sum_ext;

  assign sum_ext = {1'b0, st_r.sum} + (SUM_W + 1)'(ctl.q);
  assign st      = st_r;

  always_comb begin
    st_nxt = st_r;
    if (ctl.clr) begin
      st_nxt = STATS_RST;
    end else if (ctl.upd) begin
      if (ctl.ok) begin
        if (st_r.ok_cnt < COUNT_MAX) begin
          st_nxt.ok_cnt = st_r.ok_cnt + 1'b1;
        end
        st_nxt.sum = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        if (ctl.q < st_r.lo) begin
          st_nxt.lo = ctl.q;
        end
        if (ctl.q > st_r.hi) begin
          st_nxt.hi = ctl.q;
        end
      end else if (st_r.fail_cnt < COUNT_MAX) begin
        st_nxt.fail_cnt = st_r.fail_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATS_RST;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tks_checker.sv -----
// Port-level checker of the top-k score tracker and its bind to the top level.
// Depends on tks_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tks_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_last_image,
  input logic                        out_valid,
  input logic                        out_record_kind,
  input logic [tks_pkg::CNT_W-1:0]   out_succeeded_count,
  input logic [tks_pkg::RANK_W-1:0]  out_rank,
  input logic                        out_last_of_run
);
  import tks_pkg::*;

  `TKS_ASSERT(a_stats_beat, start && !busy |=> out_valid && !out_record_kind, "no statistics beat after an accepted item")
  `TKS_ASSERT(a_plain_last, start && !busy && !in_last_image |=> out_last_of_run, "ordinary item must end its run at once")
  `TKS_ASSERT(a_rank_step, out_valid && out_record_kind && !out_last_of_run |=> out_valid && out_record_kind && (out_rank == $past(out_rank) + 1'b1), "top-list beats must follow with rising rank")
  `TKS_ASSERT(a_busy_read, out_valid && out_record_kind |-> busy, "item accepted during top-list readout")
  `TKS_ASSERT(a_stats_hold, out_valid && out_record_kind && !out_last_of_run |=> $stable(out_succeeded_count), "statistics changed during readout")

endmodule

bind top_k_score_tracker_with_stats tks_checker u_tks_checker (.*);

`default_nettype wire
